FILE: hw/rtl/rgbaoc_pkg.sv
// shared types and constants of the rgba over compositor
package rgbaoc_pkg;

   // configuration port
   localparam int CSR_W = 9;
   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_FRAME_WIDTH  = 1'd0;
   localparam csr_index_type CSR_FRAME_HEIGHT = 1'd1;

   // input item kind
   localparam logic ACTION_COMPOSITE = 1'b0;
   localparam logic ACTION_CLEAR     = 1'b1;

   // reset size of the frame
   localparam logic [CSR_W-1:0] FRAME_SIZE_RESET = 9'd256;

   // pipeline geometry
   localparam int NUM_CH    = 3;   // red, green, blue
   localparam int DIV_STEPS = 8;   // one quotient bit per stage
   localparam int NUM_W     = 24;  // dividend width, at most 255 * 65025
   localparam int DEN_W     = 16;  // divisor width, at most 65025

   // reciprocal of 255 for 16 bit values: floor(x / 255) = (x * 32897) >> 23
   localparam logic [31:0] RECIP_255  = 32'd32897;
   localparam int          RECIP_SHFT = 23;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

endpackage

FILE: hw/rtl/rgba_over_compositor_unit.sv
// rgba over compositor: frame store with read-modify-write over pipeline
// Composites a straight-alpha RGBA8 layer, streamed in raster order, over the frame held in
// an internal store of 2^(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) 32-bit words (65536 by default),
// with the Porter-Duff over rule in exact integer arithmetic. The composited pixel is written
// back and sent out, tlast marks the last pixel of the frame. A clear item zeroes the pixel.
// After reset a clearing pass zeroes the store, one word per cycle, during which no transfer is
// taken on the request side (csr writes still land). Throughput is one pixel per clock while
// the result side does not stall and no position in flight holds the request. An item passes
// the store read, two multiply stages and an 8-stage restoring divider, one quotient bit per
// stage, on its way to the result register. An item whose frame position is still in flight
// waits until the older write has gone back to the store, so frames smaller than 12 pixels
// stall the request side.
module rgba_over_compositor_unit #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,  // in_red, in_green, in_blue, in_alpha
   input  logic                           req_tuser,  // action
   // result channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [31:0]                    rsp_tdata,  // out_red, out_green, out_blue, out_alpha
   output logic                           rsp_tlast,  // end_of_frame
   // configuration
   input  logic                           csr_we,
   input  rgbaoc_pkg::csr_index_type      csr_index,
   input  logic [rgbaoc_pkg::CSR_W-1:0]   csr_wdata
);
   import rgbaoc_pkg::*;

   localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int AW    = CW + RW;
   localparam int DEPTH = 1 << AW;
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);

   // configuration registers
   logic [CSR_W-1:0] frame_width_ff, frame_height_ff;
   logic [WW-1:0]    width_eff;
   logic [HW-1:0]    height_eff;

   // frame position
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          col_wrap, row_wrap;
   logic [AW-1:0] req_addr;

   // clearing pass after reset
   logic          clr_active_ff;
   logic [AW-1:0] clr_addr_ff;

   // store
   logic [31:0]   mem [DEPTH];
   pixel_type     rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [31:0]   mem_wdata;

   // handshake
   logic adv, acc, hazard;

   // stage 1: store read in flight
   logic          v1_ff, act1_ff, eof1_ff;
   logic [AW-1:0] addr1_ff;
   pixel_type     pix1_ff;

   // stage 2: first products
   logic             v2_ff, act2_ff, eof2_ff;
   logic [AW-1:0]    addr2_ff;
   logic [15:0]      pc1_ff [NUM_CH];
   logic [15:0]      pc0_ff [NUM_CH];
   logic [7:0]       ia2_ff;
   logic [DEN_W-1:0] d2_ff;

   // stage 3: dividends, divisor, alpha
   logic             v3_ff, act3_ff, eof3_ff;
   logic [AW-1:0]    addr3_ff;
   logic [NUM_W-1:0] num3_ff [NUM_CH];
   logic [DEN_W-1:0] d3_ff;
   logic [7:0]       alpha3_ff;

   // divider stages
   logic             vd_ff    [DIV_STEPS];
   logic             actd_ff  [DIV_STEPS];
   logic             eofd_ff  [DIV_STEPS];
   logic [AW-1:0]    addrd_ff [DIV_STEPS];
   logic [DEN_W-1:0] dd_ff    [DIV_STEPS];
   logic [7:0]       alphad_ff[DIV_STEPS];
   logic [NUM_W-1:0] remd_ff  [DIV_STEPS][NUM_CH];
   logic [7:0]       qd_ff    [DIV_STEPS][NUM_CH];
   logic [NUM_W-1:0] remd_in  [DIV_STEPS][NUM_CH];
   logic [7:0]       qd_in    [DIV_STEPS][NUM_CH];
   logic [NUM_W-1:0] rem_src  [DIV_STEPS][NUM_CH];
   logic [7:0]       q_src    [DIV_STEPS][NUM_CH];
   logic [DEN_W-1:0] d_src    [DIV_STEPS];

   // result register
   logic      out_valid_ff, out_eof_ff;
   pixel_type out_pix_ff;
   pixel_type wb_pix;
   logic      wb_zero;

   // ---------------------------------------------------------------- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_SIZE_RESET;
         frame_height_ff <= FRAME_SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // zero counts as one, oversize counts as the maximum
   always_comb begin
      if (frame_width_ff == '0) begin
         width_eff = WW'(1);
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = WW'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         height_eff = HW'(1);
      end else if (32'(frame_height_ff) > 32'(MAX_HEIGHT)) begin
         height_eff = HW'(MAX_HEIGHT);
      end else begin
         height_eff = HW'(frame_height_ff);
      end
   end

   // ---------------------------------------------------------------- raster position
   // a position at or past the last one in use wraps, so shrinking mid-frame is safe
   assign col_wrap = ((WW+1)'(col_ff) + (WW+1)'(1)) >= (WW+1)'(width_eff);
   assign row_wrap = ((HW+1)'(row_ff) + (HW+1)'(1)) >= (HW+1)'(height_eff);
   assign req_addr = {row_ff, col_ff};

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (acc) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------- handshake
   // the pipeline moves whenever the result register is free or being drained
   assign adv = !out_valid_ff || rsp_tready;

   // interlock: the pixel under the raster position must not be in flight
   always_comb begin
      hazard = (v1_ff && addr1_ff == req_addr) || (v2_ff && addr2_ff == req_addr)
            || (v3_ff && addr3_ff == req_addr);
      for (int k = 0; k < DIV_STEPS; k++) begin
         hazard = hazard || (vd_ff[k] && addrd_ff[k] == req_addr);
      end
   end

   assign req_tready = adv && !clr_active_ff && !hazard;
   assign acc        = req_tvalid && req_tready;

   // ---------------------------------------------------------------- clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (&clr_addr_ff) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- store
   assign wb_zero = (actd_ff[DIV_STEPS-1] == ACTION_CLEAR) || (dd_ff[DIV_STEPS-1] == '0);

   always_comb begin
      if (wb_zero) begin
         wb_pix = '0;
      end else begin
         wb_pix.red   = qd_ff[DIV_STEPS-1][0];
         wb_pix.green = qd_ff[DIV_STEPS-1][1];
         wb_pix.blue  = qd_ff[DIV_STEPS-1][2];
         wb_pix.alpha = alphad_ff[DIV_STEPS-1];
      end
   end

   assign mem_we    = clr_active_ff || (adv && vd_ff[DIV_STEPS-1]);
   assign mem_waddr = clr_active_ff ? clr_addr_ff : addrd_ff[DIV_STEPS-1];
   assign mem_wdata = clr_active_ff ? 32'd0 : wb_pix;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (acc) begin
         rdata_ff <= mem[req_addr];
      end
   end

   // ---------------------------------------------------------------- valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < DIV_STEPS; k++) begin
            vd_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         v1_ff        <= acc;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         vd_ff[0]     <= v3_ff;
         for (int k = 1; k < DIV_STEPS; k++) begin
            vd_ff[k] <= vd_ff[k-1];
         end
         out_valid_ff <= vd_ff[DIV_STEPS-1];
      end
   end

   // ---------------------------------------------------------------- divider step logic
   // restoring division, quotient bit DIV_STEPS-1-k is decided in stage k
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         rem_src[0][c] = num3_ff[c];
         q_src[0][c]   = '0;
         for (int k = 1; k < DIV_STEPS; k++) begin
            rem_src[k][c] = remd_ff[k-1][c];
            q_src[k][c]   = qd_ff[k-1][c];
         end
      end
      d_src[0] = d3_ff;
      for (int k = 1; k < DIV_STEPS; k++) begin
         d_src[k] = dd_ff[k-1];
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
         for (int c = 0; c < NUM_CH; c++) begin
            remd_in[k][c] = rem_src[k][c];
            qd_in[k][c]   = q_src[k][c];
            if (rem_src[k][c] >= (NUM_W'(d_src[k]) << (DIV_STEPS-1-k))) begin
               remd_in[k][c] = rem_src[k][c] - (NUM_W'(d_src[k]) << (DIV_STEPS-1-k));
               qd_in[k][c][DIV_STEPS-1-k] = 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------- payload pipeline
   always_ff @(posedge clock) begin
      if (adv) begin
         // stage 1: capture the request beside the store read
         addr1_ff <= req_addr;
         act1_ff  <= req_tuser;
         eof1_ff  <= col_wrap && row_wrap;
         pix1_ff  <= req_tdata;

         // stage 2: c1*a1, c0*a0 and the divisor
         addr2_ff <= addr1_ff;
         act2_ff  <= act1_ff;
         eof2_ff  <= eof1_ff;
         pc1_ff[0] <= 16'(pix1_ff.red)   * 16'(pix1_ff.alpha);
         pc1_ff[1] <= 16'(pix1_ff.green) * 16'(pix1_ff.alpha);
         pc1_ff[2] <= 16'(pix1_ff.blue)  * 16'(pix1_ff.alpha);
         pc0_ff[0] <= 16'(rdata_ff.red)   * 16'(rdata_ff.alpha);
         pc0_ff[1] <= 16'(rdata_ff.green) * 16'(rdata_ff.alpha);
         pc0_ff[2] <= 16'(rdata_ff.blue)  * 16'(rdata_ff.alpha);
         ia2_ff   <= 8'd255 - pix1_ff.alpha;
         d2_ff    <= 16'(pix1_ff.alpha) * 16'd255
                   + 16'(rdata_ff.alpha) * 16'(8'd255 - pix1_ff.alpha);

         // stage 3: dividends and alpha by reciprocal of 255
         addr3_ff <= addr2_ff;
         act3_ff  <= act2_ff;
         eof3_ff  <= eof2_ff;
         for (int c = 0; c < NUM_CH; c++) begin
            num3_ff[c] <= NUM_W'(pc1_ff[c]) * NUM_W'(255) + NUM_W'(pc0_ff[c]) * NUM_W'(ia2_ff);
         end
         d3_ff     <= d2_ff;
         alpha3_ff <= 8'((32'(d2_ff) * RECIP_255) >> RECIP_SHFT);

         // divider stages
         addrd_ff[0]  <= addr3_ff;
         actd_ff[0]   <= act3_ff;
         eofd_ff[0]   <= eof3_ff;
         alphad_ff[0] <= alpha3_ff;
         for (int k = 1; k < DIV_STEPS; k++) begin
            addrd_ff[k]  <= addrd_ff[k-1];
            actd_ff[k]   <= actd_ff[k-1];
            eofd_ff[k]   <= eofd_ff[k-1];
            alphad_ff[k] <= alphad_ff[k-1];
         end
         for (int k = 0; k < DIV_STEPS; k++) begin
            dd_ff[k] <= d_src[k];
            for (int c = 0; c < NUM_CH; c++) begin
               remd_ff[k][c] <= remd_in[k][c];
               qd_ff[k][c]   <= qd_in[k][c];
            end
         end

         // result register, loaded with the same word that goes back to the store
         out_pix_ff <= wb_pix;
         out_eof_ff <= eofd_ff[DIV_STEPS-1];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pix_ff;
   assign rsp_tlast  = out_eof_ff;

`ifndef SYNTHESIS
   // no request transfer while the store is being cleared
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !clr_active_ff)
      else $error("request transfer during clearing pass");

   // a stalled result register freezes the write-back
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !(vd_ff[DIV_STEPS-1] && mem_we && !clr_active_ff))
      else $error("store written while result stalled");

   // zero alpha only comes from both alphas zero, so the colour must be zero too
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[31:24] == 8'd0) |-> (rsp_tdata[23:0] == 24'd0))
      else $error("transparent result with colour");

   // an accepted pixel reaches stage one on the next edge
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v1_ff)
      else $error("accepted pixel lost");
`endif

endmodule

FILE: test/tb_rgba_over_compositor_unit.sv
// testbench of the rgba over compositor: directed table, random layers, over-rule predictor
`timescale 1ns / 100ps

module tb_rgba_over_compositor_unit;
   import rgbaoc_pkg::*;

   localparam int MAX_W      = 256;
   localparam int MAX_H      = 256;
   localparam int LATENCY    = 40;
   localparam int CYCLE_CAP  = 400000;
   localparam int N_RANDOM   = 420;

   typedef struct packed {
      logic [7:0] red, green, blue, alpha;
      logic       eof;
   } pix_result_type;

   typedef struct {
      logic       action;
      logic [7:0] red, green, blue, alpha;
      logic       known;     // expected result typed in below
      logic [31:0] exp_pix;  // alpha, blue, green, red from high to low
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   csr_index_type csr_index = CSR_FRAME_WIDTH;
   logic [CSR_W-1:0] csr_wdata = '0;

   rgba_over_compositor_unit u_top (.*);

   // clock with 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state: own copy of the frame store, position and sizes
   logic [31:0]      frame_mem [MAX_W*MAX_H];
   int unsigned      cur_col, cur_row;
   logic [CSR_W-1:0] width_reg, height_reg;

   pix_result_type   expected_pixels [$];
   int               fail_count = 0;
   int               cycle_count = 0;
   bit               random_idle = 1'b1;
   bit               long_hold = 1'b0;
   bit               hold_done = 1'b0;

   // the over rule on one item, updates the store and the raster position
   function automatic pix_result_type composite_pixel(logic action, logic [7:0] r1,
         logic [7:0] g1, logic [7:0] b1, logic [7:0] a1);
      pix_result_type res;
      int unsigned w, h, addr, d, a0;
      logic [31:0] old;
      logic [7:0]  c0 [3];
      logic [7:0]  c1 [3];
      logic [7:0]  q [3];
      w = (width_reg == 0) ? 1 : (width_reg > MAX_W ? MAX_W : width_reg);
      h = (height_reg == 0) ? 1 : (height_reg > MAX_H ? MAX_H : height_reg);
      addr = cur_row * MAX_W + cur_col;
      old = frame_mem[addr];
      res = '0;
      if (action == ACTION_COMPOSITE) begin
         a0 = 32'(old[31:24]);
         d = a1 * 255 + a0 * (255 - a1);
         c0[0] = old[7:0]; c0[1] = old[15:8]; c0[2] = old[23:16];
         c1[0] = r1; c1[1] = g1; c1[2] = b1;
         if (d != 0) begin
            for (int i = 0; i < 3; i++)
               q[i] = 8'((c1[i] * a1 * 255 + c0[i] * a0 * (255 - a1)) / d);
            res.red = q[0]; res.green = q[1]; res.blue = q[2];
            res.alpha = 8'(d / 255);
         end
      end
      frame_mem[addr] = {res.alpha, res.blue, res.green, res.red};
      if (cur_col + 1 >= w) begin
         cur_col = 0;
         if (cur_row + 1 >= h) begin
            cur_row = 0;
            res.eof = 1'b1;
         end else begin
            cur_row++;
         end
      end else begin
         cur_col++;
      end
      return res;
   endfunction

   // one request transfer, predicted at acceptance; valid stays up for back-to-back items
   task automatic send_pixel(logic action, logic [7:0] r, logic [7:0] g, logic [7:0] b,
         logic [7:0] a);
      int gap;
      if (random_idle && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {a, b, g, r};
      do @(posedge clock); while (!req_tready);
      expected_pixels.push_back(composite_pixel(action, r, g, b, a));
      @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_FRAME_WIDTH) width_reg = val;
      else height_reg = val;
      @(negedge clock);
   endtask

   // wait until every expected result has come back, then let the pipe drain
   task automatic drain;
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   // result side: back-pressure bursts and the long hold-off
   initial begin
      int hold;
      @(negedge clock);
      while (1) begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            for (int i = 0; i < 300; i++) @(negedge clock);
            long_hold = 1'b0;
         end else if (random_idle && $urandom_range(0, 6) == 0) begin
            hold = $urandom_range(1, 18);
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      pix_result_type exp_pix;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected result transfer %h", rsp_tdata);
            fail_count++;
         end else begin
            exp_pix = expected_pixels.pop_front();
            if (rsp_tdata[7:0] !== exp_pix.red) begin
               $error("out_red expected %0d actual %0d", exp_pix.red, rsp_tdata[7:0]);
               fail_count++;
            end
            if (rsp_tdata[15:8] !== exp_pix.green) begin
               $error("out_green expected %0d actual %0d", exp_pix.green, rsp_tdata[15:8]);
               fail_count++;
            end
            if (rsp_tdata[23:16] !== exp_pix.blue) begin
               $error("out_blue expected %0d actual %0d", exp_pix.blue, rsp_tdata[23:16]);
               fail_count++;
            end
            if (rsp_tdata[31:24] !== exp_pix.alpha) begin
               $error("out_alpha expected %0d actual %0d", exp_pix.alpha, rsp_tdata[31:24]);
               fail_count++;
            end
            if (rsp_tlast !== exp_pix.eof) begin
               $error("end_of_frame expected %0d actual %0d", exp_pix.eof, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // watchdog, counts past the clearing pass after reset
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // directed rows; known rows carry the pixel read straight off the over rule
   stim_row_type directed_rows [8] = '{
      '{ACTION_COMPOSITE, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 32'h00000000},
      '{ACTION_COMPOSITE, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 32'hFFFFFFFF},
      '{ACTION_COMPOSITE, 8'd12,  8'd34,  8'd56,  8'd255, 1'b1, 32'hFF38220C},
      '{ACTION_CLEAR,     8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 32'h00000000},
      '{ACTION_COMPOSITE, 8'h55,  8'hAA,  8'h0F,  8'd128, 1'b0, 32'h0},
      '{ACTION_COMPOSITE, 8'hAA,  8'h55,  8'hF0,  8'd1,   1'b0, 32'h0},
      '{ACTION_COMPOSITE, 8'd200, 8'd100, 8'd50,  8'd0,   1'b0, 32'h0},
      '{ACTION_COMPOSITE, 8'd255, 8'd0,   8'd0,   8'd254, 1'b0, 32'h0}
   };

   initial begin
      int n_frame, n_sent, wsel, hsel;
      pix_result_type first;
      foreach (frame_mem[i]) frame_mem[i] = '0;
      cur_col = 0; cur_row = 0;
      width_reg = FRAME_SIZE_RESET; height_reg = FRAME_SIZE_RESET;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // small frame so pixels get revisited
      write_csr(CSR_FRAME_WIDTH, 9'd4);
      write_csr(CSR_FRAME_HEIGHT, 9'd2);
      foreach (directed_rows[i]) begin
         send_pixel(directed_rows[i].action, directed_rows[i].red, directed_rows[i].green,
                    directed_rows[i].blue, directed_rows[i].alpha);
         if (directed_rows[i].known) begin
            first = expected_pixels[$];
            if ({first.alpha, first.blue, first.green, first.red} !== directed_rows[i].exp_pix)
            begin
               $error("directed row %0d pixel expected %h actual %h", i,
                      directed_rows[i].exp_pix, {first.alpha, first.blue, first.green,
                      first.red});
               fail_count++;
            end
         end
      end
      // second pass over the same 8 pixels flips every action: seven clears, one composite over stored content
      foreach (directed_rows[i])
         send_pixel(directed_rows[i].action ^ 1'b1, directed_rows[i].blue,
                    directed_rows[i].red, directed_rows[i].green, 8'd77);
      drain();

      // out-of-range sizes: zero and above the maximum
      write_csr(CSR_FRAME_WIDTH, 9'd0);
      write_csr(CSR_FRAME_HEIGHT, 9'h1FF);
      for (int i = 0; i < 5; i++)
         send_pixel(ACTION_COMPOSITE, 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom));
      drain();

      // size change mid-frame: position is kept and wraps
      write_csr(CSR_FRAME_WIDTH, 9'd3);
      write_csr(CSR_FRAME_HEIGHT, 9'd1);
      for (int i = 0; i < 4; i++)
         send_pixel(ACTION_COMPOSITE, 8'd9, 8'd8, 8'd7, 8'd200);
      drain();

      // random phases, each with its own frame size, mostly small
      n_sent = 0;
      while (n_sent < N_RANDOM) begin
         wsel = $urandom_range(0, 9);
         hsel = $urandom_range(0, 9);
         write_csr(CSR_FRAME_WIDTH, 9'(wsel == 0 ? 1 : (wsel == 1 ? 256 :
                   $urandom_range(1, 20))));
         write_csr(CSR_FRAME_HEIGHT, 9'(hsel == 0 ? 1 : (hsel == 1 ? 256 :
                   $urandom_range(1, 6))));
         if (n_sent > 100 && !hold_done) begin
            long_hold = 1'b1;
            hold_done = 1'b1;
         end
         if (n_sent > N_RANDOM - 80) random_idle = 1'b0;
         n_frame = $urandom_range(20, 60);
         for (int i = 0; i < n_frame; i++) begin
            // mostly compositing, alpha biased to the extremes
            case ($urandom_range(0, 7))
               0: send_pixel(ACTION_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom));
               1: send_pixel(ACTION_COMPOSITE, 8'($urandom), 8'($urandom), 8'($urandom),
                             8'd0);
               2: send_pixel(ACTION_COMPOSITE, 8'($urandom), 8'($urandom), 8'($urandom),
                             8'd255);
               default: send_pixel(ACTION_COMPOSITE, 8'($urandom), 8'($urandom),
                                   8'($urandom), 8'($urandom));
            endcase
         end
         n_sent += n_frame;
         drain();
      end

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/rgbaoc_pkg.sv
hw/rtl/rgba_over_compositor_unit.sv
test/tb_rgba_over_compositor_unit.sv
